/* rtl/core/wtcs_pkg.sv */
package wtcs_pkg;

  localparam int NUM_TEXTURES = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int POS_W        = 40;
  localparam int STEP_W       = 32;
  localparam int ROW_W        = 13;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NORTH_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUTH_SIZE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EAST_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEST_SIZE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd4;

  // Texture slots.
  localparam logic [1:0] TEX_NORTH = 2'd0;
  localparam logic [1:0] TEX_SOUTH = 2'd1;
  localparam logic [1:0] TEX_EAST  = 2'd2;
  localparam logic [1:0] TEX_WEST  = 2'd3;

  // Input command and result kind codes.
  localparam logic CMD_PIXEL   = 1'b1;
  localparam logic KIND_DEPTH  = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic [31:0]       TEX_SIZE_RESET      = 32'h0040_0040;
  localparam logic [12:0]       SCREEN_HEIGHT_RESET = 13'd480;
  localparam logic [ROW_W-1:0]  ROW_LIMIT_MAX       = 13'd4096;
  localparam logic [STEP_W-1:0] STEP_MAX            = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               cmd;
    logic               hit_side;
    logic signed [19:0] ray_dx;
    logic signed [19:0] ray_dy;
    logic [25:0]        player_px;
    logic [25:0]        player_py;
    logic [25:0]        wall_dist;
    logic [15:0]        slice_height;
    logic [11:0]        span_start;
    logic [12:0]        span_end;
    logic [11:0]        column;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] out_column;
    logic [11:0] out_row;
    logic [1:0]  tex_select;
    logic        tex_ok;
    logic [15:0] texel_col;
    logic [15:0] texel_row;
    logic [31:0] texel_offset;
    logic [25:0] depth;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FRAC,
    S_TEXCOL,
    S_DIV,
    S_STEP,
    S_POS,
    S_COL_OUT,
    S_PIX_OUT
  } state_t;

  typedef struct packed {
    logic latch_col;
    logic latch_pix;
    logic frac;
    logic texcol;
    logic div_step;
    logic step_load;
    logic pos_load;
    logic out_col;
    logic out_pix;
  } dp_cmd_t;

  typedef struct packed {
    logic in_cmd;
    logic in_ok;
    logic span_active;
    logic div_last;
  } dp_status_t;

endpackage

/* rtl/core/wtcs_ctrl.sv */
module wtcs_ctrl
  import wtcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output logic       in_stall,
  output logic       out_valid,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (status.in_cmd == CMD_PIXEL) begin
            // A pixel past the end of the span is dropped without a result.
            state_next = status.span_active ? S_PIX_OUT : S_IDLE;
          end else begin
            state_next = status.in_ok ? S_FRAC : S_COL_OUT;
          end
        end
      end
      S_FRAC:    state_next = S_TEXCOL;
      S_TEXCOL:  state_next = S_DIV;
      S_DIV:     state_next = status.div_last ? S_STEP : S_DIV;
      S_STEP:    state_next = S_POS;
      S_POS:     state_next = S_COL_OUT;
      S_COL_OUT: state_next = out_free ? S_IDLE : S_COL_OUT;
      S_PIX_OUT: state_next = out_free ? S_IDLE : S_PIX_OUT;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (status.in_cmd == CMD_PIXEL) begin
            cmd.latch_pix = status.span_active;
          end else begin
            cmd.latch_col = 1'b1;
          end
        end
      end
      S_FRAC:    cmd.frac      = 1'b1;
      S_TEXCOL:  cmd.texcol    = 1'b1;
      S_DIV:     cmd.div_step  = 1'b1;
      S_STEP:    cmd.step_load = 1'b1;
      S_POS:     cmd.pos_load  = 1'b1;
      S_COL_OUT: cmd.out_col   = out_free;
      S_PIX_OUT: cmd.out_pix   = out_free;
      default:   cmd           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_col || cmd.out_pix) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/wtcs_dp.sv */
module wtcs_dp
  import wtcs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  in_item_t             in_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output out_item_t            out_data
);

  localparam int F   = FRAC_BITS;
  localparam int NW  = 16 + F;
  localparam int DCW = $clog2(NW + 1);
  localparam int QW  = (NW > STEP_W) ? NW : STEP_W;
  localparam int PW  = (2 * F > 47) ? 2 * F : 47;
  localparam int IYW = POS_W - F;

  // Configuration registers.
  logic [31:0] tex_size [NUM_TEXTURES];
  logic [12:0] screen_height;

  // Column state.
  logic [1:0]        cur_tex;
  logic              cur_tex_ok;
  logic [15:0]       cur_texel_col;
  logic [STEP_W-1:0] tex_step;
  logic [POS_W-1:0]  tex_pos;
  logic [ROW_W-1:0]  cur_row;
  logic [ROW_W-1:0]  row_limit;
  logic [11:0]       cur_column;

  // Working registers of a column start.
  in_item_t    item;
  logic        mirror;
  logic [F-1:0] frac;
  logic [15:0] trow;
  logic [15:0] div_rem;
  logic [NW-1:0] div_q;
  logic [DCW-1:0] div_cnt;
  out_item_t   out_r;

  // Decode of the incoming column start.
  logic       dx_pos, dx_neg, dy_pos, dy_neg;
  logic       dec_ok, dec_mirror;
  logic [1:0] dec_sel;

  assign dx_neg = in_data.ray_dx[19];
  assign dy_neg = in_data.ray_dy[19];
  assign dx_pos = !in_data.ray_dx[19] && (in_data.ray_dx != '0);
  assign dy_pos = !in_data.ray_dy[19] && (in_data.ray_dy != '0);

  always_comb begin
    dec_ok     = 1'b1;
    dec_sel    = TEX_NORTH;
    dec_mirror = 1'b0;
    priority if (in_data.hit_side && dy_pos) begin
      dec_sel = TEX_SOUTH;
    end else if (in_data.hit_side && dy_neg) begin
      dec_sel    = TEX_NORTH;
      dec_mirror = 1'b1;
    end else if (!in_data.hit_side && dx_pos) begin
      dec_sel    = TEX_EAST;
      dec_mirror = 1'b1;
    end else if (!in_data.hit_side && dx_neg) begin
      dec_sel = TEX_WEST;
    end else begin
      dec_ok = 1'b0;
    end
  end

  assign status.in_cmd      = in_data.cmd;
  assign status.in_ok       = dec_ok;
  assign status.span_active = (cur_row < row_limit);
  assign status.div_last    = (div_cnt == DCW'(1));

  // Size of the selected texture.
  logic [31:0] sel_size;
  logic [15:0] sel_w, sel_h;

  assign sel_size = tex_size[cur_tex];
  assign sel_w    = sel_size[31:16];
  assign sel_h    = sel_size[15:0];

  logic [15:0] lh_eff;
  assign lh_eff = (item.slice_height == '0) ? 16'd1 : item.slice_height;

  // Fractional wall hit: base + (dist * dir) / 2^F, low F bits only.
  logic [25:0]        base;
  logic signed [19:0] dir_s;
  logic signed [26:0] dist_s;
  logic signed [46:0] prod_full;
  logic signed [PW-1:0] prod_ext;
  logic [F-1:0]       frac_next;

  assign base      = item.hit_side ? item.player_px : item.player_py;
  assign dir_s     = item.hit_side ? item.ray_dx : item.ray_dy;
  assign dist_s    = $signed({1'b0, item.wall_dist});
  assign prod_full = dist_s * dir_s;
  assign prod_ext  = PW'(prod_full);
  assign frac_next = base[F-1:0] + prod_ext[2*F-1:F];

  // Texture column from the fraction and the texture width.
  logic [F+15:0] tprod;
  logic [15:0]   tx_raw;
  logic [15:0]   texcol_val;

  assign tprod  = frac * sel_w;
  assign tx_raw = tprod[F+15:F];

  always_comb begin
    if (sel_w == '0) begin
      texcol_val = '0;
    end else if (mirror) begin
      texcol_val = sel_w - 16'd1 - tx_raw;
    end else begin
      texcol_val = tx_raw;
    end
  end

  // Restoring divider, one quotient bit a cycle.
  logic [16:0] div_r2;
  logic        div_ge;
  logic [15:0] div_rem_next;

  assign div_r2       = {div_rem, div_q[NW-1]};
  assign div_ge       = (div_r2 >= {1'b0, lh_eff});
  assign div_rem_next = div_ge ? 16'(div_r2 - {1'b0, lh_eff}) : div_r2[15:0];

  logic [QW-1:0]     q_ext;
  logic [STEP_W-1:0] step_sat;

  assign q_ext    = QW'(div_q);
  assign step_sat = (q_ext > QW'(STEP_MAX)) ? STEP_MAX : q_ext[STEP_W-1:0];

  // Start position of the texture walk.
  logic signed [17:0] off;
  logic               off_pos;
  logic [47:0]        pos_prod;
  logic [POS_W-1:0]   pos_val;

  assign off = $signed({6'b0, item.span_start}) - $signed({6'b0, screen_height[12:1]})
             + $signed({3'b0, lh_eff[15:1]});
  assign off_pos  = !off[17] && (off != '0);
  assign pos_prod = off[15:0] * tex_step;

  always_comb begin
    if (!off_pos) begin
      pos_val = '0;
    end else if (pos_prod[47:POS_W] != '0) begin
      pos_val = '1;
    end else begin
      pos_val = pos_prod[POS_W-1:0];
    end
  end

  // Texture row of the next pixel, clamped to the last row.
  logic [IYW-1:0] iy;
  logic [15:0]    h_m1;
  logic [15:0]    trow_next;

  assign iy   = tex_pos[POS_W-1:F];
  assign h_m1 = sel_h - 16'd1;

  always_comb begin
    if (!cur_tex_ok || (sel_h == '0)) begin
      trow_next = '0;
    end else if (iy > IYW'(h_m1)) begin
      trow_next = h_m1;
    end else begin
      trow_next = iy[15:0];
    end
  end

  logic [31:0]      row_prod;
  logic [31:0]      offset_val;
  logic [POS_W:0]   pos_sum;
  logic [ROW_W-1:0] row_inc;

  assign row_prod   = sel_w * trow;
  assign offset_val = cur_tex_ok ? (row_prod + {16'b0, cur_texel_col}) : '0;
  assign pos_sum    = {1'b0, tex_pos} + {{(POS_W + 1 - STEP_W){1'b0}}, tex_step};
  assign row_inc    = cur_row + ROW_W'(1);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TEXTURES; i++) begin
        tex_size[i] <= TEX_SIZE_RESET;
      end
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NORTH_SIZE:    tex_size[TEX_NORTH] <= cfg_data;
        CFG_SOUTH_SIZE:    tex_size[TEX_SOUTH] <= cfg_data;
        CFG_EAST_SIZE:     tex_size[TEX_EAST]  <= cfg_data;
        CFG_WEST_SIZE:     tex_size[TEX_WEST]  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height       <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Column state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_tex       <= TEX_NORTH;
      cur_tex_ok    <= 1'b0;
      cur_texel_col <= '0;
      tex_step      <= '0;
      tex_pos       <= '0;
      cur_row       <= '0;
      row_limit     <= '0;
      cur_column    <= '0;
    end else begin
      if (cmd.latch_col) begin
        cur_tex       <= dec_ok ? dec_sel : TEX_NORTH;
        cur_tex_ok    <= dec_ok;
        cur_texel_col <= '0;
        tex_step      <= '0;
        tex_pos       <= '0;
        cur_row       <= {1'b0, in_data.span_start};
        row_limit     <= (in_data.span_end > ROW_LIMIT_MAX) ? ROW_LIMIT_MAX : in_data.span_end;
        cur_column    <= in_data.column;
      end
      if (cmd.texcol) begin
        cur_texel_col <= texcol_val;
      end
      if (cmd.step_load) begin
        tex_step <= step_sat;
      end
      if (cmd.pos_load) begin
        tex_pos <= pos_val;
      end
      if (cmd.out_pix) begin
        tex_pos <= pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
        cur_row <= row_inc;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_col) begin
      item   <= in_data;
      mirror <= dec_mirror;
    end
    if (cmd.latch_pix) begin
      trow <= trow_next;
    end
    if (cmd.frac) begin
      frac <= frac_next;
    end
    if (cmd.texcol) begin
      div_rem <= '0;
      div_q   <= {sel_h, {F{1'b0}}};
    end else if (cmd.div_step) begin
      div_rem <= div_rem_next;
      div_q   <= {div_q[NW-2:0], div_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.texcol) begin
      div_cnt <= DCW'(NW);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - DCW'(1);
    end
  end

  // Result register.
  out_item_t col_rec, pix_rec;

  always_comb begin
    col_rec            = '0;
    col_rec.kind       = KIND_DEPTH;
    col_rec.out_column = cur_column;
    col_rec.tex_select = cur_tex;
    col_rec.tex_ok     = cur_tex_ok;
    col_rec.texel_col  = cur_texel_col;
    col_rec.depth      = item.wall_dist;

    pix_rec              = '0;
    pix_rec.kind         = KIND_PIXEL;
    pix_rec.out_column   = cur_column;
    pix_rec.out_row      = cur_row[11:0];
    pix_rec.tex_select   = cur_tex;
    pix_rec.tex_ok       = cur_tex_ok;
    pix_rec.texel_col    = cur_texel_col;
    pix_rec.texel_row    = trow;
    pix_rec.texel_offset = offset_val;
    pix_rec.last         = (row_inc == row_limit);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_col) begin
      out_r <= col_rec;
    end else if (cmd.out_pix) begin
      out_r <= pix_rec;
    end
  end

  assign out_data = out_r;

endmodule

/* rtl/core/wall_texture_column_sampler.sv */
// Textured wall column sampler for a grid raycaster.
// Input channel (in_valid, in_stall, in_data): a transaction with cmd 0 starts a
// column and returns one depth record; a transaction with cmd 1 returns the
// texel address of the next row, or nothing once the span is used up.
// Output channel (out_valid, out_stall, out_data): at most one result per transaction,
// held in an output register until the receiver takes it.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): always
// ready; write it only while the block is idle. Unknown indexes are ignored.
// A pixel result is loaded into the output register from S_PIX_OUT, and the block
// returns to idle before it takes a new pixel, so pixels do not overlap.
// A column start steps through S_FRAC, S_TEXCOL, S_DIV, S_STEP, S_POS and
// S_COL_OUT; the restoring divider forms the texture step one quotient bit per
// cycle in S_DIV; a column start on a ray with no usable direction skips to S_COL_OUT.
// One transaction is worked on at a time; the next one is accepted as soon as
// the previous result is loaded, even while that result still waits.
// When the receiver stalls, a finished result stays in the output register and
// the block holds in_stall until it can load its next result.
// Reset (rst, synchronous) restores the 64x64 texture sizes, a screen height
// of 480 and an empty span, so pixels before a column start return nothing.
module wall_texture_column_sampler
  import wtcs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  wtcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  wtcs_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
